// ===== src/bsa_pkg.sv =====
package bsa_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned DMAX_W   = 12;
  localparam int unsigned MV_W     = 15;
  localparam int unsigned PCT_W    = 7;

  // Serial divider: dividend covers a 12 x 16 bit product.
  localparam int unsigned DIVD_W = SAMPLE_W + CFG_W;
  localparam int unsigned DIVS_W = CFG_W;
  localparam int unsigned DCNT_W = $clog2(DIVD_W);

  localparam logic [MV_W-1:0]  MV_MAX      = 15'd32767;
  localparam logic [MV_W-1:0]  PCT_LOW_MV  = 15'd3350;
  localparam logic [MV_W-1:0]  PCT_HIGH_MV = 15'd4100;
  localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;

  // 100 / 750 equals 2 / 15; floor(y / 15) is (y * 2185) >> 15 for y below 4681.
  localparam int unsigned PCT_Y_W     = 11;
  localparam int unsigned PCT_RECIP_W = 12;
  localparam int unsigned PCT_SHIFT   = 15;
  localparam logic [PCT_RECIP_W-1:0] PCT_RECIP = 12'd2185;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_NUM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_MV = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_FILL,
    ST_LD_MEAN,
    ST_LD_MV,
    ST_DIV_MV,
    ST_FIN,
    ST_OUT
  } bsa_state_e;

endpackage

// ===== src/battery_sample_averager.sv =====
// Battery sample averager with a downward slew limit.
// Input channel (in_valid_i / in_ready_o) takes an item of op_i and sample_i.
// With op_i low the sample may drop at most delta_max below the previous
// stored sample; with op_i high it is stored as is and refills the whole ring.
// Output channel (out_valid_o / out_ready_i) returns one item per input: the
// stored sample, the ring mean, the mean in millivolts and a charge percent.
// Configuration writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always
// taken and must only be issued while the block is idle.
// The ring lives in a memory with one read port and one write port; a running
// sum is updated by read, modify and write of the oldest entry.
// After accept an item walks the states ST_UPD, ST_LD_MEAN, ST_LD_MV, ST_DIV_MV,
// ST_FIN and ST_OUT; a purge item also sweeps the ring in ST_FILL. The mean is a
// reciprocal multiply; the millivolt scaling uses a one-bit-per-cycle divider.
// One item is in flight at a time; a new item is taken only back in ST_IDLE.
// The output register holds a finished item while the receiver stalls, and a
// new input item is accepted meanwhile; that item waits at the end until the
// register frees up.
// Reset clears the ring (through per-entry valid bits), the running sum, the
// write index and the previous sample, and loads the register reset values.
module battery_sample_averager #(
  parameter int unsigned AVG_DEPTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [bsa_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 op_i,
  input  logic [bsa_pkg::SAMPLE_W-1:0]         sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bsa_pkg::SAMPLE_W-1:0]         stored_sample_o,
  output logic [bsa_pkg::SAMPLE_W-1:0]         average_raw_o,
  output logic [bsa_pkg::MV_W-1:0]             voltage_mv_o,
  output logic [bsa_pkg::PCT_W-1:0]            percent_o
);

  localparam int unsigned IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int unsigned SUM_W = bsa_pkg::SAMPLE_W + $clog2(AVG_DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AVG_DEPTH - 1);
  localparam int unsigned MEAN_SH = SUM_W + $clog2(AVG_DEPTH);
  localparam logic [SUM_W:0] MEAN_RECIP =
    (SUM_W + 1)'(((64'd1 << MEAN_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  // Configuration registers.
  logic [bsa_pkg::DMAX_W-1:0] cfg_dmax_q;
  logic [bsa_pkg::CFG_W-1:0]  cfg_num_q, cfg_den_q, cfg_offset_q;

  // Ring memory and its per-entry valid bits.
  logic [bsa_pkg::SAMPLE_W-1:0] mem [AVG_DEPTH];
  logic [bsa_pkg::SAMPLE_W-1:0] rd_q;
  logic [AVG_DEPTH-1:0]         vld_q, vld_d;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;

  bsa_pkg::bsa_state_e state_q, state_d;

  logic [IDX_W-1:0]             widx_q, widx_d, cnt_q, cnt_d;
  logic [bsa_pkg::SAMPLE_W-1:0] prev_q, prev_d, cur_q, cur_d;
  logic                         purge_q, purge_d;
  logic [SUM_W-1:0]             sum_q, sum_d;
  logic [bsa_pkg::SAMPLE_W-1:0] mean_q, mean_d;
  logic [bsa_pkg::MV_W-1:0]     mv_q, mv_d;

  // Divider registers.
  logic [bsa_pkg::DIVD_W-1:0] quo_q, quo_d;
  logic [bsa_pkg::DIVS_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [bsa_pkg::DCNT_W-1:0] dcnt_q, dcnt_d;

  // Output register.
  logic                         out_valid_q, out_valid_d;
  logic [bsa_pkg::SAMPLE_W-1:0] o_stored_q, o_stored_d, o_avg_q, o_avg_d;
  logic [bsa_pkg::MV_W-1:0]     o_mv_q, o_mv_d;
  logic [bsa_pkg::PCT_W-1:0]    o_pct_q, o_pct_d;

  // Combinational helpers.
  logic                           in_acc;
  logic [bsa_pkg::SAMPLE_W-1:0]   floor_val, lim_sample, old_val;
  logic [2*SUM_W:0]               mean_prod;
  logic [bsa_pkg::SAMPLE_W-1:0]   mean_val;
  logic [bsa_pkg::DIVS_W:0]       rem_shift;
  logic                           div_ge;
  logic [bsa_pkg::DIVS_W-1:0]     rem_step;
  logic [bsa_pkg::DIVD_W-1:0]     quo_step;
  logic                           div_last;
  logic signed [bsa_pkg::DIVD_W+1:0] mv_sum;
  logic [bsa_pkg::MV_W-1:0]       pct_x;
  logic [bsa_pkg::PCT_Y_W-1:0]    pct_y;
  logic [bsa_pkg::PCT_Y_W+bsa_pkg::PCT_RECIP_W-1:0] pct_prod;
  logic [bsa_pkg::PCT_W-1:0]      pct_val;

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == bsa_pkg::ST_IDLE);
  assign in_acc          = in_valid_i && in_ready_o;
  assign out_valid_o     = out_valid_q;
  assign stored_sample_o = o_stored_q;
  assign average_raw_o   = o_avg_q;
  assign voltage_mv_o    = o_mv_q;
  assign percent_o       = o_pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dmax_q   <= 12'd32;
      cfg_num_q    <= 16'd1;
      cfg_den_q    <= 16'd1;
      cfg_offset_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bsa_pkg::CFG_DELTA_MAX: cfg_dmax_q   <= cfg_data_i[bsa_pkg::DMAX_W-1:0];
        bsa_pkg::CFG_SCALE_NUM: cfg_num_q    <= cfg_data_i;
        bsa_pkg::CFG_SCALE_DEN: cfg_den_q    <= cfg_data_i;
        bsa_pkg::CFG_OFFSET_MV: cfg_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= cur_q;
    end
    rd_q <= mem[widx_q];
  end

  // Slew limit: no floor while the previous sample is below delta_max.
  assign floor_val  = prev_q - cfg_dmax_q;
  assign lim_sample = (!op_i && (prev_q >= cfg_dmax_q) && (sample_i < floor_val)) ?
                      floor_val : sample_i;
  assign old_val    = vld_q[widx_q] ? rd_q : '0;

  // The mean is a multiply by the rounded-up reciprocal of AVG_DEPTH; with the
  // shift covering the whole sum width the quotient comes out exact.
  assign mean_prod = (2*SUM_W + 1)'(sum_q) * (2*SUM_W + 1)'(MEAN_RECIP);
  assign mean_val  = mean_prod[MEAN_SH +: bsa_pkg::SAMPLE_W];

  // One restoring divider step.
  assign rem_shift = {rem_q, quo_q[bsa_pkg::DIVD_W-1]};
  assign div_ge    = (rem_shift >= {1'b0, dvs_q});
  assign rem_step  = div_ge ? bsa_pkg::DIVS_W'(rem_shift - {1'b0, dvs_q}) :
                              rem_shift[bsa_pkg::DIVS_W-1:0];
  assign quo_step  = {quo_q[bsa_pkg::DIVD_W-2:0], div_ge};
  assign div_last  = (dcnt_q == bsa_pkg::DCNT_W'(bsa_pkg::DIVD_W - 1));

  assign mv_sum = $signed({2'b00, quo_q}) +
                  $signed({{(bsa_pkg::DIVD_W + 2 - bsa_pkg::CFG_W){cfg_offset_q[bsa_pkg::CFG_W-1]}},
                           cfg_offset_q});

  assign pct_x    = mv_q - bsa_pkg::PCT_LOW_MV;
  assign pct_y    = {pct_x[bsa_pkg::PCT_Y_W-2:0], 1'b0};
  assign pct_prod = (bsa_pkg::PCT_Y_W + bsa_pkg::PCT_RECIP_W)'(pct_y) *
                    (bsa_pkg::PCT_Y_W + bsa_pkg::PCT_RECIP_W)'(bsa_pkg::PCT_RECIP);

  always_comb begin
    if (mv_q < bsa_pkg::PCT_LOW_MV) begin
      pct_val = '0;
    end else if (mv_q >= bsa_pkg::PCT_HIGH_MV) begin
      pct_val = bsa_pkg::PCT_FULL;
    end else begin
      pct_val = pct_prod[bsa_pkg::PCT_SHIFT +: bsa_pkg::PCT_W];
    end
  end

  always_comb begin
    state_d     = state_q;
    widx_d      = widx_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    purge_d     = purge_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    mv_d        = mv_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    dcnt_d      = dcnt_q;
    vld_d       = vld_q;
    mem_we      = 1'b0;
    mem_waddr   = widx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_stored_d  = o_stored_q;
    o_avg_d     = o_avg_q;
    o_mv_d      = o_mv_q;
    o_pct_d     = o_pct_q;

    case (state_q)
      bsa_pkg::ST_IDLE: begin
        if (in_acc) begin
          cur_d   = lim_sample;
          purge_d = op_i;
          state_d = bsa_pkg::ST_UPD;
        end
      end
      bsa_pkg::ST_UPD: begin
        prev_d = cur_q;
        if (purge_q) begin
          cnt_d   = '0;
          widx_d  = '0;
          sum_d   = SUM_W'(cur_q) * SUM_W'(AVG_DEPTH);
          state_d = bsa_pkg::ST_FILL;
        end else begin
          mem_we        = 1'b1;
          vld_d[widx_q] = 1'b1;
          sum_d         = sum_q - SUM_W'(old_val) + SUM_W'(cur_q);
          widx_d        = (widx_q == LAST_IDX) ? '0 : widx_q + 1'b1;
          state_d       = bsa_pkg::ST_LD_MEAN;
        end
      end
      bsa_pkg::ST_FILL: begin
        mem_we       = 1'b1;
        mem_waddr    = cnt_q;
        vld_d[cnt_q] = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = bsa_pkg::ST_LD_MEAN;
        end
      end
      bsa_pkg::ST_LD_MEAN: begin
        quo_d   = bsa_pkg::DIVD_W'(mean_val);
        state_d = bsa_pkg::ST_LD_MV;
      end
      bsa_pkg::ST_LD_MV: begin
        mean_d  = quo_q[bsa_pkg::SAMPLE_W-1:0];
        quo_d   = bsa_pkg::DIVD_W'(quo_q[bsa_pkg::SAMPLE_W-1:0]) *
                  bsa_pkg::DIVD_W'(cfg_num_q);
        rem_d   = '0;
        dvs_d   = cfg_den_q;
        dcnt_d  = '0;
        state_d = bsa_pkg::ST_DIV_MV;
      end
      bsa_pkg::ST_DIV_MV: begin
        quo_d  = quo_step;
        rem_d  = rem_step;
        dcnt_d = dcnt_q + 1'b1;
        if (div_last) begin
          state_d = bsa_pkg::ST_FIN;
        end
      end
      bsa_pkg::ST_FIN: begin
        // A zero denominator counts as a saturated quotient.
        if (cfg_den_q == '0) begin
          mv_d = bsa_pkg::MV_MAX;
        end else if (mv_sum < 0) begin
          mv_d = '0;
        end else if (mv_sum > $signed((bsa_pkg::DIVD_W + 2)'(bsa_pkg::MV_MAX))) begin
          mv_d = bsa_pkg::MV_MAX;
        end else begin
          mv_d = mv_sum[bsa_pkg::MV_W-1:0];
        end
        state_d = bsa_pkg::ST_OUT;
      end
      bsa_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_stored_d  = cur_q;
          o_avg_d     = mean_q;
          o_mv_d      = mv_q;
          o_pct_d     = pct_val;
          state_d     = bsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsa_pkg::ST_IDLE;
      widx_q      <= '0;
      cnt_q       <= '0;
      prev_q      <= '0;
      purge_q     <= 1'b0;
      sum_q       <= '0;
      dcnt_q      <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      widx_q      <= widx_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      purge_q     <= purge_d;
      sum_q       <= sum_d;
      dcnt_q      <= dcnt_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    mean_q     <= mean_d;
    mv_q       <= mv_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    o_stored_q <= o_stored_d;
    o_avg_q    <= o_avg_d;
    o_mv_q     <= o_mv_d;
    o_pct_q    <= o_pct_d;
  end

`ifndef SYNTHESIS
  a_widx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    widx_q <= LAST_IDX)
    else $error("write index beyond ring depth");

  a_accept_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == bsa_pkg::ST_UPD)
    else $error("accepted item did not start the ring update");

  a_out_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bsa_pkg::ST_OUT))
    else $error("output item appeared without a finished computation");

  a_purge_resets_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bsa_pkg::ST_FILL |-> widx_q == '0)
    else $error("purge sweep with nonzero write index");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RING_DEPTH   = 8;
  localparam int unsigned SLOT_W       = $clog2(RING_DEPTH);
  localparam int unsigned PHASES       = 5;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int          LOW_MV       = int'(bsa_pkg::PCT_LOW_MV);
  localparam int          SPAN_MV      = int'(bsa_pkg::PCT_HIGH_MV) - int'(bsa_pkg::PCT_LOW_MV);
  localparam int          FULL_PCT     = int'(bsa_pkg::PCT_FULL);
  localparam int          TOP_MV       = int'(bsa_pkg::MV_MAX);

  typedef struct packed {
    logic [bsa_pkg::SAMPLE_W-1:0] stored;
    logic [bsa_pkg::SAMPLE_W-1:0] mean;
    logic [bsa_pkg::MV_W-1:0]     mv;
    logic [bsa_pkg::PCT_W-1:0]    pct;
  } reading_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic                          op;
    logic [bsa_pkg::SAMPLE_W-1:0]  raw;
    logic [bsa_pkg::CFG_IDX_W-1:0] reg_index;
    logic [bsa_pkg::CFG_W-1:0]     reg_data;
    logic                          typed;
    reading_t                      want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [bsa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bsa_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic item_op;
  logic [bsa_pkg::SAMPLE_W-1:0] item_sample;
  logic out_valid;
  logic out_ready;
  logic [bsa_pkg::SAMPLE_W-1:0] stored_sample;
  logic [bsa_pkg::SAMPLE_W-1:0] average_raw;
  logic [bsa_pkg::MV_W-1:0] voltage_mv;
  logic [bsa_pkg::PCT_W-1:0] percent;

  // Predictor copy of the block's state and registers.
  logic [bsa_pkg::SAMPLE_W-1:0] charge_ring [RING_DEPTH];
  logic [SLOT_W-1:0] ring_slot;
  logic [bsa_pkg::SAMPLE_W-1:0] last_stored;
  logic [bsa_pkg::DMAX_W-1:0] slew_limit;
  logic [bsa_pkg::CFG_W-1:0] mv_num;
  logic [bsa_pkg::CFG_W-1:0] mv_den;
  logic signed [bsa_pkg::CFG_W-1:0] mv_offset;

  reading_t readings_due[$];
  plan_row_t directed_plan[$];

  int unsigned error_count = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned cycle_count = 0;
  logic no_idle = 1'b0;
  logic long_hold_done = 1'b0;

  battery_sample_averager #(
    .AVG_DEPTH(RING_DEPTH)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (item_op),
    .sample_i       (item_sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .stored_sample_o(stored_sample),
    .average_raw_o  (average_raw),
    .voltage_mv_o   (voltage_mv),
    .percent_o      (percent)
  );

  always #1 clk = ~clk;

  function automatic reading_t predict_reading(input logic purge,
                                               input logic [bsa_pkg::SAMPLE_W-1:0] raw);
    reading_t r;
    logic [bsa_pkg::SAMPLE_W-1:0] kept;
    int unsigned total;
    longint level;
    int pct_val;
    kept = raw;
    // No floor exists while the last stored sample is below the slew limit.
    if (!purge && last_stored >= slew_limit && raw < last_stored - slew_limit)
      kept = last_stored - slew_limit;
    charge_ring[ring_slot] = kept;
    ring_slot = SLOT_W'((ring_slot + 1) % RING_DEPTH);
    last_stored = kept;
    if (purge) begin
      foreach (charge_ring[i]) charge_ring[i] = kept;
      ring_slot = '0;
    end
    total = 0;
    foreach (charge_ring[i]) total += charge_ring[i];
    r.stored = kept;
    r.mean = bsa_pkg::SAMPLE_W'(total / RING_DEPTH);
    if (mv_den == '0) begin
      level = TOP_MV;
    end else begin
      level = longint'(r.mean) * longint'(mv_num) / longint'(mv_den) + longint'(mv_offset);
    end
    if (level < 0) level = 0;
    if (level > TOP_MV) level = TOP_MV;
    r.mv = level[bsa_pkg::MV_W-1:0];
    pct_val = (int'(level) < LOW_MV) ? 0 : FULL_PCT * (int'(level) - LOW_MV) / SPAN_MV;
    if (pct_val > FULL_PCT) pct_val = FULL_PCT;
    r.pct = pct_val[bsa_pkg::PCT_W-1:0];
    return r;
  endfunction

  function automatic void plan_item(input logic purge,
                                    input logic [bsa_pkg::SAMPLE_W-1:0] raw);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = purge;
    row.raw = raw;
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_checked(input logic purge,
                                       input logic [bsa_pkg::SAMPLE_W-1:0] raw,
                                       input int stored, input int mean, input int mv,
                                       input int pct);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.op = purge;
    row.raw = raw;
    row.typed = 1'b1;
    row.want.stored = stored[bsa_pkg::SAMPLE_W-1:0];
    row.want.mean = mean[bsa_pkg::SAMPLE_W-1:0];
    row.want.mv = mv[bsa_pkg::MV_W-1:0];
    row.want.pct = pct[bsa_pkg::PCT_W-1:0];
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_reg(input logic [bsa_pkg::CFG_IDX_W-1:0] index,
                                   input logic [bsa_pkg::CFG_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.reg_index = index;
    row.reg_data = data;
    directed_plan.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch on result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
    error_count++;
  endtask

  // The valid line is left high here; the caller lowers it after a run of writes.
  task automatic write_reg(input logic [bsa_pkg::CFG_IDX_W-1:0] index,
                           input logic [bsa_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      bsa_pkg::CFG_DELTA_MAX: slew_limit = data[bsa_pkg::DMAX_W-1:0];
      bsa_pkg::CFG_SCALE_NUM: mv_num = data;
      bsa_pkg::CFG_SCALE_DEN: mv_den = data;
      bsa_pkg::CFG_OFFSET_MV: mv_offset = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic send_item(input logic purge, input logic [bsa_pkg::SAMPLE_W-1:0] raw,
                           input logic typed, input reading_t want);
    reading_t due;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    item_op <= purge;
    item_sample <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due = predict_reading(purge, raw);
    readings_due.push_back(typed ? want : due);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    plan_row_t row;
    logic purge;
    logic [bsa_pkg::SAMPLE_W-1:0] raw;
    int near;
    logic [bsa_pkg::CFG_W-1:0] pick_delta;
    logic [bsa_pkg::CFG_W-1:0] pick_num;
    logic [bsa_pkg::CFG_W-1:0] pick_den;
    logic [bsa_pkg::CFG_W-1:0] pick_offset;

    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    item_op <= 1'b0;
    item_sample <= '0;
    foreach (charge_ring[i]) charge_ring[i] = '0;
    ring_slot = '0;
    last_stored = '0;
    slew_limit = 12'd32;
    mv_num = 16'd1;
    mv_den = 16'd1;
    mv_offset = 16'sd0;

    // Reset settings first: slew floor, purge extremes, previous below and at the limit.
    plan_checked(1'b0, 12'd0, 0, 0, 0, 0);
    plan_checked(1'b0, 12'd4095, 4095, 511, 511, 0);
    plan_item(1'b0, 12'd0);
    plan_checked(1'b1, 12'd4095, 4095, 4095, 4095, 99);
    plan_checked(1'b1, 12'd0, 0, 0, 0, 0);
    plan_item(1'b0, 12'd20);
    plan_item(1'b0, 12'd0);
    plan_checked(1'b1, 12'd32, 32, 32, 32, 0);
    plan_item(1'b0, 12'd0);
    // With no slew allowed a limited sample can never drop.
    plan_reg(bsa_pkg::CFG_DELTA_MAX, 16'd0);
    plan_checked(1'b1, 12'd100, 100, 100, 100, 0);
    plan_item(1'b0, 12'd50);
    plan_reg(bsa_pkg::CFG_DELTA_MAX, 16'd4095);
    plan_item(1'b0, 12'd0);
    plan_reg(bsa_pkg::CFG_SCALE_NUM, 16'hFFFF);
    plan_checked(1'b1, 12'd4095, 4095, 4095, 32767, 100);
    // A zero denominator saturates the conversion.
    plan_reg(bsa_pkg::CFG_SCALE_DEN, 16'd0);
    plan_checked(1'b1, 12'd5, 5, 5, 32767, 100);
    plan_reg(bsa_pkg::CFG_SCALE_NUM, 16'd0);
    plan_reg(bsa_pkg::CFG_SCALE_DEN, 16'hFFFF);
    plan_reg(bsa_pkg::CFG_OFFSET_MV, 16'h8000);
    plan_checked(1'b1, 12'd4095, 4095, 4095, 0, 0);
    plan_reg(bsa_pkg::CFG_OFFSET_MV, 16'h7FFF);
    plan_checked(1'b1, 12'd1, 1, 1, 32767, 100);
    // Offset puts the percent knee right on the raw count.
    plan_reg(bsa_pkg::CFG_SCALE_NUM, 16'd1);
    plan_reg(bsa_pkg::CFG_SCALE_DEN, 16'd1);
    plan_reg(bsa_pkg::CFG_OFFSET_MV, 16'd3350);
    plan_checked(1'b1, 12'd750, 750, 750, 4100, 100);
    plan_checked(1'b1, 12'd749, 749, 749, 4099, 99);
    plan_checked(1'b1, 12'd0, 0, 0, 3350, 0);
    plan_item(1'b0, 12'd4095);
    plan_item(1'b0, 12'd2048);
    plan_item(1'b0, 12'd1);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < directed_plan.size(); n++) begin
      row = directed_plan[n];
      if (row.kind == ROW_REG) begin
        if (n == 0 || directed_plan[n-1].kind != ROW_REG) wait_idle();
        write_reg(row.reg_index, row.reg_data);
        if (n + 1 == directed_plan.size() || directed_plan[n+1].kind != ROW_REG)
          cfg_valid <= 1'b0;
      end else begin
        send_item(row.op, row.raw, row.typed, row.want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0: pick_delta = 16'd0;
        1: pick_delta = 16'd4095;
        2: pick_delta = bsa_pkg::CFG_W'($urandom_range(1, 100));
        default: pick_delta = bsa_pkg::CFG_W'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 4))
        0: pick_num = 16'd0;
        1: pick_num = 16'hFFFF;
        2: pick_num = 16'd1;
        default: pick_num = bsa_pkg::CFG_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 7))
        0: pick_den = 16'd0;
        1: pick_den = 16'hFFFF;
        2, 3: pick_den = 16'd1;
        default: pick_den = bsa_pkg::CFG_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 5))
        0: pick_offset = 16'h8000;
        1: pick_offset = 16'h7FFF;
        2: pick_offset = 16'd0;
        default: pick_offset = bsa_pkg::CFG_W'($urandom_range(0, 8000) - 4000);
      endcase
      write_reg(bsa_pkg::CFG_DELTA_MAX, pick_delta);
      write_reg(bsa_pkg::CFG_SCALE_NUM, pick_num);
      write_reg(bsa_pkg::CFG_SCALE_DEN, pick_den);
      write_reg(bsa_pkg::CFG_OFFSET_MV, pick_offset);
      cfg_valid <= 1'b0;
      if (p == PHASES - 1) no_idle = 1'b1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        purge = ($urandom_range(0, 99) < 8);
        if ($urandom_range(0, 1) == 0) begin
          raw = bsa_pkg::SAMPLE_W'($urandom_range(0, 4095));
        end else begin
          // Stay near the last stored value so the slew floor is hit often.
          near = int'(last_stored) + int'($urandom_range(0, 600)) - 300;
          if (near < 0) near = 0;
          if (near > 4095) near = 4095;
          raw = near[bsa_pkg::SAMPLE_W-1:0];
        end
        send_item(purge, raw, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d items (%0d in the directed table) across %0d register writes,",
             items_sent, directed_plan.size() - reg_writes + PHASES * 4, reg_writes);
    $display("including limited and purge samples, saturation and a long output stall.");
    if (error_count == 0) begin
      $display("[battery_sample_averager] OK");
    end else begin
      $display("[battery_sample_averager] ERROR");
    end
    $finish;
  end

  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && results_seen >= 100) begin
        // Hold off long enough for the block to fill and drop its input ready.
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (readings_due.size() == 0) begin
        report_mismatch("item with nothing pending, stored_sample", stored_sample, 0);
      end else begin
        want = readings_due.pop_front();
        if (stored_sample !== want.stored)
          report_mismatch("stored_sample", stored_sample, want.stored);
        if (average_raw !== want.mean) report_mismatch("average_raw", average_raw, want.mean);
        if (voltage_mv !== want.mv) report_mismatch("voltage_mv", voltage_mv, want.mv);
        if (percent !== want.pct) report_mismatch("percent", percent, want.pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending.", cycle_count,
               readings_due.size());
      $display("[battery_sample_averager] ERROR");
      $finish;
    end
  end

endmodule
